// ----- hdl/cbre_pkg.sv -----
// shared constants, widths and codes of the cluster bitmap range engine
package cbre_pkg;

  // window geometry
  localparam int WIN_CLUSTERS = 65536;
  localparam int BM_BYTES     = WIN_CLUSTERS / 8;
  localparam int BM_AW        = $clog2(BM_BYTES);
  localparam int REL_W        = $clog2(WIN_CLUSTERS);

  // field widths
  localparam int ACT_W  = 2;
  localparam int BIDX_W = 13;
  localparam int BYTE_W = 8;
  localparam int CL_W   = 48;
  localparam int CNT_W  = 32;
  localparam int LEN_W  = 32;
  localparam int CS_W   = 21;
  localparam int FILL_W = 17;
  localparam int RUN_W  = 17;
  localparam int DVD_W  = CL_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLUSTER_SIZE  = 2'd0,
    CFG_WINDOW_START  = 2'd1,
    CFG_WINDOW_FILLED = 2'd2,
    CFG_SPARE         = 2'd3
  } cfg_idx_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

endpackage

// ----- hdl/cbre_if.sv -----
// request and result channel interfaces
interface cbre_req_if import cbre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BIDX_W-1:0] byte_index;
  logic [BYTE_W-1:0] byte_data;
  logic [CL_W-1:0]   range_start;
  logic [CNT_W-1:0]  range_count;
  logic [CL_W-1:0]   offset;
  logic [LEN_W-1:0]  length;

  modport source (output valid, action, byte_index, byte_data, range_start, range_count,
                  offset, length, input ready);
  modport sink (input valid, action, byte_index, byte_data, range_start, range_count,
                offset, length, output ready);
endinterface

interface cbre_res_if import cbre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             covered;
  logic             first_used;
  logic [RUN_W-1:0] run_count;
  logic [RUN_W-1:0] used_run_count;
  logic             any_used;
  logic [LEN_W-1:0] run_bytes;
  logic [CL_W-1:0]  next_start;
  logic [CNT_W-1:0] remaining_count;

  modport source (output valid, covered, first_used, run_count, used_run_count, any_used,
                  run_bytes, next_start, remaining_count, input ready);
  modport sink (input valid, covered, first_used, run_count, used_run_count, any_used,
                run_bytes, next_start, remaining_count, output ready);
endinterface

// ----- hdl/cbre_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module cbre_div import cbre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [CS_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o,
  output logic [CS_W-1:0]  rem_o
);

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic [CNT_BITS-1:0] cnt_q;
  logic                busy_q, done_q;
  logic [DVD_W-1:0]    quo_q;
  logic [CS_W:0]       rem_q;
  logic [CS_W-1:0]     dsr_q;
  logic [CS_W:0]       trial;

  // shift in the next dividend bit
  assign trial = {rem_q[CS_W-1:0], quo_q[DVD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(DVD_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        if (trial >= {1'b0, dsr_q}) begin
          rem_q <= trial - {1'b0, dsr_q};
          quo_q <= {quo_q[DVD_W-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[DVD_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[CS_W-1:0];

endmodule

// ----- hdl/cluster_bitmap_range_engine_top.sv -----
// channel    | dir | handshake          | carries
// req_i      | in  | valid/ready        | action, byte_index/data, range, offset/length
// res_o      | out | valid/ready        | query answers, next_start, remaining_count
// cfg_*_i    | in  | write enable only  | cluster_size, window_start, window_filled
// a load writes its byte directly; a set/clear reads and rewrites each bitmap byte touched
// a query runs two 49-step divisions, then scans the bitmap byte by byte
// the bitmap memory's single registered read port sets the scan rate
// one request is worked at a time; a finished result waits in the output register
// while the next request is already taken; reset clears control and the window registers,
// sets the cluster size to 4096, and the bitmap itself is undefined until loaded
module cluster_bitmap_range_engine_top import cbre_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cbre_req_if.sink              req_i,
  cbre_res_if.source            res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_RCHK, S_RRD, S_RMOD,
    S_QD0, S_QW0, S_QD1, S_QW1, S_QCHK, S_QRD0, S_QFIRST, S_QRD, S_QSCAN,
    S_QMUL, S_QBYT, S_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [CS_W-1:0]   cs_q;
  logic [CL_W-1:0]   ws_q;
  logic [FILL_W-1:0] filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q     <= CS_W'(4096);
      ws_q     <= '0;
      filled_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CLUSTER_SIZE:  cs_q     <= cfg_data_i[CS_W-1:0];
        CFG_WINDOW_START:  ws_q     <= cfg_data_i[CL_W-1:0];
        CFG_WINDOW_FILLED: filled_q <= cfg_data_i[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window size and cluster size
  logic [FILL_W-1:0] fill_eff;
  logic [CS_W-1:0]   cs_eff;
  logic [DVD_W-1:0]  win_last;
  assign fill_eff = (filled_q > FILL_W'(WIN_CLUSTERS)) ? FILL_W'(WIN_CLUSTERS) : filled_q;
  assign cs_eff   = (cs_q == '0) ? CS_W'(1) : cs_q;
  assign win_last = {1'b0, ws_q} + DVD_W'(fill_eff) - DVD_W'(1);

  // request registers
  logic              set_q;
  logic [CL_W-1:0]   start_q, off_q;
  logic [CNT_W-1:0]  count_q;
  logic [LEN_W-1:0]  len_q;
  logic [DVD_W-1:0]  endoff_q;
  logic [DVD_W-1:0]  first_cl_q, last_cl_q;
  logic [CS_W-1:0]   remoff_q;

  // walk registers
  logic [REL_W-1:0]  cur_q;
  logic [RUN_W-1:0]  rem_q;
  logic [RUN_W-1:0]  run_q;
  logic              first_q;
  logic [CS_W+RUN_W-1:0] prod_q;

  // result registers
  logic              r_cov, r_first, r_any;
  logic [RUN_W-1:0]  r_run, r_urun;
  logic [LEN_W-1:0]  r_bytes;
  logic [CL_W-1:0]   r_next;
  logic [CNT_W-1:0]  r_remain;

  // output register
  logic              out_valid_q;
  logic              o_cov, o_first, o_any;
  logic [RUN_W-1:0]  o_run, o_urun;
  logic [LEN_W-1:0]  o_bytes;
  logic [CL_W-1:0]   o_next;
  logic [CNT_W-1:0]  o_remain;

  logic accept;
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // divider
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [CS_W-1:0]  div_rem;
  assign div_start = (state_q == S_QD0) || (state_q == S_QD1);
  assign div_dvd   = (state_q == S_QD0) ? {1'b0, off_q} : endoff_q;

  cbre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cs_eff),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // bitmap memory
  logic [BYTE_W-1:0] mem [BM_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we;
  logic [BM_AW-1:0]  mem_wa;
  logic [BYTE_W-1:0] mem_wd;

  // bit lanes of the current byte that fall inside the walk
  logic [2:0] lo;
  logic [3:0] avail, take, hi, pos, adv;
  logic [7:0] inr, mis;
  logic       hit;

  always_comb begin
    lo    = cur_q[2:0];
    avail = 4'd8 - {1'b0, lo};
    take  = (rem_q < RUN_W'(avail)) ? rem_q[3:0] : avail;
    hi    = {1'b0, lo} + take;
    pos   = 4'd0;
    for (int p = 0; p < 8; p++) begin
      inr[p] = (4'(p) >= {1'b0, lo}) && (4'(p) < hi);
      mis[p] = inr[p] && (rdata_q[p] != first_q);
    end
    for (int p = 7; p >= 0; p--) begin
      if (mis[p]) pos = 4'(p);
    end
    hit = |mis;
    adv = hit ? (pos - {1'b0, lo}) : take;
  end

  // single write port: loads and range updates
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_q[REL_W-1:3];
    mem_wd = set_q ? (rdata_q | inr) : (rdata_q & ~inr);
    if (accept && action_e'(req_i.action) == ACT_LOAD) begin
      mem_we = 1'b1;
      mem_wa = req_i.byte_index[BM_AW-1:0];
      mem_wd = req_i.byte_data;
    end else if (state_q == S_RMOD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[cur_q[REL_W-1:3]];
  end

  // range clipping helpers
  logic              r_inwin;
  logic [DVD_W-1:0]  span_w;
  logic [RUN_W-1:0]  span, rng_n;
  assign r_inwin = (fill_eff != '0) && (start_q >= ws_q) && ({1'b0, start_q} <= win_last);
  assign span_w  = win_last - {1'b0, start_q} + DVD_W'(1);
  assign span    = span_w[RUN_W-1:0];
  assign rng_n   = (count_q < CNT_W'(span)) ? count_q[RUN_W-1:0] : span;

  // query helpers
  logic              q_cov;
  logic [DVD_W-1:0]  rel_w, qn_w;
  logic [CS_W+RUN_W:0] bytes_w;
  assign q_cov   = (fill_eff != '0) && (first_cl_q >= {1'b0, ws_q}) && (last_cl_q <= win_last);
  assign rel_w   = first_cl_q - {1'b0, ws_q};
  assign qn_w    = last_cl_q - first_cl_q + DVD_W'(1);
  assign bytes_w = (CS_W+RUN_W+1)'(cs_eff - remoff_q) + (CS_W+RUN_W+1)'(prod_q);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // the finishing state refills the slot itself
      if (res_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            set_q    <= (action_e'(req_i.action) == ACT_SET);
            start_q  <= req_i.range_start;
            count_q  <= req_i.range_count;
            off_q    <= req_i.offset;
            len_q    <= req_i.length;
            endoff_q <= {1'b0, req_i.offset} + DVD_W'(req_i.length) -
                        DVD_W'(req_i.length != '0);
            run_q    <= '0;
            r_cov    <= 1'b0;
            r_first  <= 1'b0;
            r_any    <= 1'b0;
            r_run    <= '0;
            r_urun   <= '0;
            r_bytes  <= '0;
            r_next   <= '0;
            r_remain <= '0;
            case (action_e'(req_i.action))
              ACT_LOAD:  state_q <= S_DONE;
              ACT_SET:   state_q <= S_RCHK;
              ACT_CLEAR: state_q <= S_RCHK;
              ACT_QUERY: state_q <= S_QD0;
              default:   state_q <= S_DONE;
            endcase
          end
        end
        S_RCHK: begin
          if (r_inwin) begin
            cur_q    <= REL_W'(start_q - ws_q);
            rem_q    <= rng_n;
            r_next   <= start_q + CL_W'(rng_n);
            r_remain <= count_q - CNT_W'(rng_n);
            state_q  <= (rng_n == '0) ? S_DONE : S_RRD;
          end else begin
            r_next   <= start_q;
            r_remain <= count_q;
            state_q  <= S_DONE;
          end
        end
        S_RRD: state_q <= S_RMOD;
        S_RMOD: begin
          cur_q <= cur_q + REL_W'(take);
          rem_q <= rem_q - RUN_W'(take);
          state_q <= (rem_q == RUN_W'(take)) ? S_DONE : S_RRD;
        end
        S_QD0: state_q <= S_QW0;
        S_QW0: begin
          if (div_done) begin
            first_cl_q <= div_quo;
            remoff_q   <= div_rem;
            state_q    <= S_QD1;
          end
        end
        S_QD1: state_q <= S_QW1;
        S_QW1: begin
          if (div_done) begin
            last_cl_q <= div_quo;
            state_q   <= S_QCHK;
          end
        end
        S_QCHK: begin
          if (q_cov) begin
            r_cov   <= 1'b1;
            cur_q   <= rel_w[REL_W-1:0];
            rem_q   <= (len_q != '0) ? qn_w[RUN_W-1:0] : '0;
            state_q <= S_QRD0;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_QRD0: state_q <= S_QFIRST;
        S_QFIRST: begin
          first_q <= rdata_q[cur_q[2:0]];
          r_first <= rdata_q[cur_q[2:0]];
          state_q <= (rem_q == '0) ? S_DONE : S_QSCAN;
        end
        S_QRD: state_q <= S_QSCAN;
        S_QSCAN: begin
          run_q <= run_q + RUN_W'(adv);
          if (hit || rem_q == RUN_W'(take)) begin
            r_any   <= first_q || hit;
            state_q <= S_QMUL;
          end else begin
            cur_q   <= cur_q + REL_W'(take);
            rem_q   <= rem_q - RUN_W'(take);
            state_q <= S_QRD;
          end
        end
        S_QMUL: begin
          prod_q  <= (run_q - RUN_W'(1)) * cs_eff;
          r_run   <= run_q;
          r_urun  <= first_q ? run_q : '0;
          state_q <= (run_q == '0) ? S_DONE : S_QBYT;
        end
        S_QBYT: begin
          r_bytes <= (bytes_w > (CS_W+RUN_W+1)'(len_q)) ? len_q : bytes_w[LEN_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            o_cov    <= r_cov;
            o_first  <= r_first;
            o_any    <= r_any;
            o_run    <= r_run;
            o_urun   <= r_urun;
            o_bytes  <= r_bytes;
            o_next   <= r_next;
            o_remain <= r_remain;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result port
  assign res_o.valid           = out_valid_q;
  assign res_o.covered         = o_cov;
  assign res_o.first_used      = o_first;
  assign res_o.run_count       = o_run;
  assign res_o.used_run_count  = o_urun;
  assign res_o.any_used        = o_any;
  assign res_o.run_bytes       = o_bytes;
  assign res_o.next_start      = o_next;
  assign res_o.remaining_count = o_remain;

`ifndef NO_ASSERTIONS
  // a range update never writes with nothing left to apply
  a_rmod_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMOD) |-> (rem_q != '0))
    else $error("range write with empty remainder");

  // an uncovered query result carries no run
  a_uncov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !o_cov) |-> (o_run == '0 && o_bytes == '0 && !o_any))
    else $error("uncovered result with nonzero run");

  // a result leaves the sequencer only when the output slot can take it
  a_done_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !res_o.ready) |=> (state_q == S_DONE))
    else $error("result overwrote a pending one");
`endif

endmodule
